// ===== hdl/sbd_pkg.sv =====
// Shared types and constants of the supersample box downsampler.
// No dependencies; every other file of the block imports this package.
package sbd_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int SUM_W      = 20;
    localparam int COORD_W    = 11;
    localparam int FACTOR_W   = 4;
    localparam int POS_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int ROW_W      = 10;
    localparam int MAX_HEIGHT = 1024;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_FACTOR = 8;

    localparam logic [FACTOR_W-1:0] RST_FACTOR        = 4'd1;
    localparam logic [POS_W-1:0]    RST_REGION_X      = 10'd0;
    localparam logic [POS_W-1:0]    RST_REGION_Y      = 10'd0;
    localparam logic [SIZE_W-1:0]   RST_REGION_WIDTH  = 11'd1024;
    localparam logic [SIZE_W-1:0]   RST_REGION_HEIGHT = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic accum;
        logic mul;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/sbd_if.sv =====
// Pixel stream interfaces of the supersample box downsampler.
// Depends on sbd_pkg for the field widths.
interface sbd_pix_in_if;
    import sbd_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface sbd_pix_out_if;
    import sbd_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   red_out;
    logic [PIX_W-1:0]   green_out;
    logic [PIX_W-1:0]   blue_out;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               region_done;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output out_x, output out_y, output region_done, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input out_x, input out_y, input region_done, output ready);
endinterface

// ===== hdl/sbd_ctrl.sv =====
// Controller of the supersample box downsampler: sequences one input beat
// through read, accumulate, multiply and output load. Depends on sbd_pkg.
module sbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sbd_pkg::t_dp_status i_status,
    output sbd_pkg::t_dp_cmd   o_cmd
);
    import sbd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   w_fire;

    assign w_fire     = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = w_fire;
        o_cmd.accum    = (r_state == ST_ACC);
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.load_out = (r_state == ST_EMIT) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_fire) begin
                        r_state    <= ST_ACC;
                        r_in_ready <= 1'b0;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                ST_ACC: begin
                    if (i_status.last) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Hold the finished pixel until the output register has room.
                    if (i_status.out_free) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== hdl/sbd_dp.sv =====
// Datapath of the supersample box downsampler: configuration registers,
// position counters, column sum memory, reciprocal divide and output register.
// Depends on sbd_pkg.
module sbd_dp #(
    parameter int MAX_WIDTH  = sbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = sbd_pkg::DEF_MAX_FACTOR
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  sbd_pkg::t_dp_cmd               i_cmd,
    output sbd_pkg::t_dp_status            o_status,
    input  logic [sbd_pkg::PIX_W-1:0]      i_red_in,
    input  logic [sbd_pkg::PIX_W-1:0]      i_green_in,
    input  logic [sbd_pkg::PIX_W-1:0]      i_blue_in,
    output logic [sbd_pkg::PIX_W-1:0]      o_red_out,
    output logic [sbd_pkg::PIX_W-1:0]      o_green_out,
    output logic [sbd_pkg::PIX_W-1:0]      o_blue_out,
    output logic [sbd_pkg::COORD_W-1:0]    o_out_x,
    output logic [sbd_pkg::COORD_W-1:0]    o_out_y,
    output logic                           o_region_done,
    output logic                           o_out_valid,
    input  logic                           i_out_ready
);
    import sbd_pkg::*;

    localparam int FCNT_W   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int FEFF_W   = $clog2(MAX_FACTOR + 1);
    localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WEFF_W   = $clog2(MAX_WIDTH + 1);
    localparam int AREA_LOG = $clog2(MAX_FACTOR * MAX_FACTOR);
    localparam int SHIFT    = SUM_W + AREA_LOG;
    localparam int RECIP_W  = SHIFT + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int TAB_N    = 1 << FEFF_W;
    localparam int WORD_W   = NUM_CH * SUM_W;

    // Configuration registers.
    logic [FACTOR_W-1:0] r_factor;
    logic [POS_W-1:0]    r_region_x;
    logic [POS_W-1:0]    r_region_y;
    logic [SIZE_W-1:0]   r_region_width;
    logic [SIZE_W-1:0]   r_region_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor        <= RST_FACTOR;
            r_region_x      <= RST_REGION_X;
            r_region_y      <= RST_REGION_Y;
            r_region_width  <= RST_REGION_WIDTH;
            r_region_height <= RST_REGION_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FACTOR:        r_factor        <= i_cfg_data[FACTOR_W-1:0];
                CFG_REGION_X:      r_region_x      <= i_cfg_data[POS_W-1:0];
                CFG_REGION_Y:      r_region_y      <= i_cfg_data[POS_W-1:0];
                CFG_REGION_WIDTH:  r_region_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_REGION_HEIGHT: r_region_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, large values saturate.
    logic [FEFF_W-1:0] w_f;
    logic [WEFF_W-1:0] w_w;
    logic [SIZE_W-1:0] w_h;

    always_comb begin
        if (r_factor == '0) begin
            w_f = FEFF_W'(1);
        end else if (32'(r_factor) > 32'(MAX_FACTOR)) begin
            w_f = FEFF_W'(MAX_FACTOR);
        end else begin
            w_f = FEFF_W'(r_factor);
        end
        if (r_region_width == '0) begin
            w_w = WEFF_W'(1);
        end else if (32'(r_region_width) > 32'(MAX_WIDTH)) begin
            w_w = WEFF_W'(MAX_WIDTH);
        end else begin
            w_w = WEFF_W'(r_region_width);
        end
        if (r_region_height == '0) begin
            w_h = SIZE_W'(1);
        end else if (32'(r_region_height) > 32'(MAX_HEIGHT)) begin
            w_h = SIZE_W'(MAX_HEIGHT);
        end else begin
            w_h = r_region_height;
        end
    end

    // Position counters.
    logic [FCNT_W-1:0] r_sub_col;
    logic [FCNT_W-1:0] r_sub_row;
    logic [COL_W-1:0]  r_block_col;
    logic [ROW_W-1:0]  r_block_row;

    logic [FEFF_W-1:0] w_sc_inc;
    logic [FEFF_W-1:0] w_sr_inc;
    logic [WEFF_W-1:0] w_bc_inc;
    logic [SIZE_W-1:0] w_br_inc;
    logic              w_first;
    logic              w_last;
    logic              w_done;

    assign w_sc_inc = FEFF_W'(r_sub_col) + FEFF_W'(1);
    assign w_sr_inc = FEFF_W'(r_sub_row) + FEFF_W'(1);
    assign w_bc_inc = WEFF_W'(r_block_col) + WEFF_W'(1);
    assign w_br_inc = SIZE_W'(r_block_row) + SIZE_W'(1);

    assign w_first = (r_sub_row == '0) && (r_sub_col == '0);
    assign w_last  = (w_sr_inc == w_f) && (w_sc_inc == w_f);
    assign w_done  = (w_bc_inc == w_w) && (w_br_inc == w_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_col   <= '0;
            r_sub_row   <= '0;
            r_block_col <= '0;
            r_block_row <= '0;
        end else if (i_cmd.capture) begin
            // A counter at or beyond its limit wraps at its next advance.
            if (w_sc_inc >= w_f) begin
                r_sub_col <= '0;
                if (w_bc_inc >= w_w) begin
                    r_block_col <= '0;
                    if (w_sr_inc >= w_f) begin
                        r_sub_row <= '0;
                        if (w_br_inc >= w_h) begin
                            r_block_row <= '0;
                        end else begin
                            r_block_row <= ROW_W'(w_br_inc);
                        end
                    end else begin
                        r_sub_row <= FCNT_W'(w_sr_inc);
                    end
                end else begin
                    r_block_col <= COL_W'(w_bc_inc);
                end
            end else begin
                r_sub_col <= FCNT_W'(w_sc_inc);
            end
        end
    end

    // Beat capture and column sum read.
    logic [WORD_W-1:0]  mem [MAX_WIDTH];
    logic [WORD_W-1:0]  r_rd_data;
    logic [PIX_W-1:0]   r_px [NUM_CH];
    logic [COL_W-1:0]   r_col;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic               r_first;
    logic               r_last;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_data <= mem[r_block_col];
            r_px[0]   <= i_red_in;
            r_px[1]   <= i_green_in;
            r_px[2]   <= i_blue_in;
            r_col     <= r_block_col;
            r_x       <= COORD_W'(r_region_x) + COORD_W'(r_block_col);
            r_y       <= COORD_W'(r_region_y) + COORD_W'(r_block_row);
            r_first   <= w_first;
            r_last    <= w_last;
            r_done    <= w_done;
        end
    end

    // Accumulate and write back; the first sample of a block overwrites.
    logic [SUM_W-1:0]  w_new_sum [NUM_CH];
    logic [WORD_W-1:0] w_new_word;
    logic [SUM_W-1:0]  r_sum [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_first) begin
                w_new_sum[c] = SUM_W'(r_px[c]);
            end else begin
                w_new_sum[c] = r_rd_data[c*SUM_W +: SUM_W] + SUM_W'(r_px[c]);
            end
            w_new_word[c*SUM_W +: SUM_W] = w_new_sum[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            mem[r_col] <= w_new_word;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= w_new_sum[c];
            end
        end
    end

    // Division by factor squared as a multiply by a rounded-up reciprocal.
    // The shift covers the sum width plus the largest area, which makes the
    // quotient exact for every sum value.
    logic [RECIP_W-1:0] w_recip_tab [TAB_N];

    for (genvar g = 0; g < TAB_N; g++) begin : g_recip
        localparam longint unsigned AREA =
            (g >= 1 && g <= MAX_FACTOR) ? longint'(g) * longint'(g) : 64'd1;
        localparam longint unsigned RECIP = ((64'd1 << SHIFT) + AREA - 64'd1) / AREA;
        assign w_recip_tab[g] = RECIP_W'(RECIP);
    end

    logic [RECIP_W-1:0] w_recip;
    logic [PROD_W-1:0]  r_prod [NUM_CH];

    assign w_recip = w_recip_tab[w_f];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_prod[c] <= PROD_W'(r_sum[c]) * PROD_W'(w_recip);
            end
        end
    end

    // Output register.
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_red_out;
    logic [PIX_W-1:0]   r_green_out;
    logic [PIX_W-1:0]   r_blue_out;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic               r_region_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_red_out     <= r_prod[0][SHIFT +: PIX_W];
            r_green_out   <= r_prod[1][SHIFT +: PIX_W];
            r_blue_out    <= r_prod[2][SHIFT +: PIX_W];
            r_out_x       <= r_x;
            r_out_y       <= r_y;
            r_region_done <= r_done;
        end
    end

    assign o_red_out     = r_red_out;
    assign o_green_out   = r_green_out;
    assign o_blue_out    = r_blue_out;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_region_done = r_region_done;
    assign o_out_valid   = r_out_valid;

    always_comb begin
        o_status          = '0;
        o_status.last     = r_last;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

endmodule

// ===== hdl/supersample_box_downsampler.sv =====
// Supersample box downsampler, top level: controller and datapath.
// Depends on sbd_pkg, sbd_if, sbd_ctrl and sbd_dp.
//
// Takes supersampled RGB pixels in raster order and emits one averaged pixel
// per factor by factor block, with its output coordinates and a flag on the
// region's last pixel. Each input beat is captured and accumulated; a beat
// that completes a block then passes through the multiply and output load,
// as set by the read-modify-write of the single-port column sum memory and the
// registered reciprocal multiply. The finished pixel sits in an output register,
// so input beats keep flowing while it waits; only a second finished pixel
// stalls until the first one is taken. The column sum memory is not cleared
// after reset: each sum is overwritten by the first sample of its block. The user
// must write configuration while the block is idle; the block does not enforce it.
module supersample_box_downsampler #(
    parameter int MAX_WIDTH  = sbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = sbd_pkg::DEF_MAX_FACTOR
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sbd_pix_in_if.sink                     i_pix,
    sbd_pix_out_if.source                  o_pix
);
    import sbd_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sbd_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_red_in      (i_pix.red_in),
        .i_green_in    (i_pix.green_in),
        .i_blue_in     (i_pix.blue_in),
        .o_red_out     (o_pix.red_out),
        .o_green_out   (o_pix.green_out),
        .o_blue_out    (o_pix.blue_out),
        .o_out_x       (o_pix.out_x),
        .o_out_y       (o_pix.out_y),
        .o_region_done (o_pix.region_done),
        .o_out_valid   (o_pix.valid),
        .i_out_ready   (o_pix.ready)
    );

`ifndef SYNTHESIS
    // One beat in flight at a time: the cycle after an accept is never ready.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("input accepted while a beat is still in flight");

    // The output register is loaded only when it is empty or being drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_pix.valid || o_pix.ready))
        else $error("pending output pixel overwritten");

    // A new output pixel appears only after a load command.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pix.valid) |-> $past(w_cmd.load_out))
        else $error("output valid raised without a load");

    // The multiply step follows only an accumulate of a block's last sample.
    a_mul_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul |-> ($past(w_cmd.accum) && $past(w_status.last)))
        else $error("multiply issued without a completed block");
`endif

endmodule
